// File: rtl/ewst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewst_pkg
// Shared widths, default parameters and types of the edge walker span table.
// ----------------------------------------------------------------------------
package ewst_pkg;

  // Fixed widths of the channel payload fields.
  localparam int FIELD_W = 10;
  localparam int ROWSEL_W = 8;

  // Defaults for the top level parameters.
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_COORD_BITS = 10;

  // Request codes.
  localparam logic REQ_TRACE = 1'b0;
  localparam logic REQ_SPAN = 1'b1;

  // Flags reported by the step unit for the current point.
  typedef struct packed {
    logic minor_step;
    logic row_miss;
  } step_flags_t;

endpackage

// File: rtl/ewst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewst_req_if
// Request channel: trace a segment or read the span entries of one row.
// ----------------------------------------------------------------------------
interface ewst_req_if import ewst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [FIELD_W-1:0]  x_start;
  logic [FIELD_W-1:0]  y_start;
  logic [FIELD_W-1:0]  x_end;
  logic [FIELD_W-1:0]  y_end;
  logic                right_side;
  logic [FIELD_W-1:0]  base_row;
  logic [ROWSEL_W-1:0] row_index;

  modport source (
    output valid, req_type, x_start, y_start, x_end, y_end, right_side, base_row,
           row_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, x_start, y_start, x_end, y_end, right_side, base_row,
           row_index,
    output ready
  );
endinterface

// File: rtl/ewst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewst_rsp_if
// Response channel: one status and span entry pair per request.
// ----------------------------------------------------------------------------
interface ewst_rsp_if import ewst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [FIELD_W-1:0] left_x;
  logic [FIELD_W-1:0] left_y;
  logic [FIELD_W-1:0] right_x;
  logic [FIELD_W-1:0] right_y;

  modport source (
    output valid, status, left_x, left_y, right_x, right_y,
    input  ready
  );

  modport sink (
    input  valid, status, left_x, left_y, right_x, right_y,
    output ready
  );
endinterface

// File: rtl/ewst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewst_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ewst_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ewst_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewst_walk
// Shared Bresenham step unit: decision update and scanline row check.
// ----------------------------------------------------------------------------
module ewst_walk import ewst_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic signed [COORD_BITS+2:0]   p,
  input  logic        [COORD_BITS:0]     d_minor,
  input  logic        [COORD_BITS:0]     d_major,
  input  logic        [COORD_BITS-1:0]   y,
  input  logic        [COORD_BITS-1:0]   base,
  output logic signed [COORD_BITS+2:0]   p_next,
  output step_flags_t                    flags,
  output logic [$clog2(MAX_ROWS)-1:0]    row_addr
);

  localparam int PW = COORD_BITS + 3;
  localparam int RW = $clog2(MAX_ROWS);

  logic              take;
  logic signed [PW-1:0] sub;
  logic [COORD_BITS:0]  row;

  // A non-negative decision value moves the minor coordinate one step.
  assign take = ~p[PW-1];
  assign sub = take ? $signed(PW'(d_major)) : '0;
  assign p_next = p + $signed(PW'(d_minor)) - sub;

  assign row = {1'b0, y} - {1'b0, base};
  assign row_addr = RW'(row[COORD_BITS-1:0]);

  assign flags.minor_step = take;
  assign flags.row_miss = row[COORD_BITS]
                          || (32'(row[COORD_BITS-1:0]) >= 32'(MAX_ROWS));

endmodule

// File: rtl/edge_walk_span_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_walk_span_table
// Polygon edge walker that fills left and right span tables by Bresenham.
// ----------------------------------------------------------------------------
// A trace request walks the segment one point per clock cycle along its major
// axis through a single shared step unit and writes the visited scanlines into
// the left or right span RAM at row y - base_row; the walk covers N points on
// the major axis (|dx| + 1 or |dy| + 1, at most 2**COORD_BITS) and its
// response is loaded in S_FINISH once the output register is free. A span
// request reads both tables at row_index in S_READ and answers from the
// registered RAM read in S_FINISH. The block takes one request at a time:
// ready is high only while it is idle, and it may accept the next request
// while the previous response still waits on the output register. Span
// table contents are undefined until a trace writes them, so a span read
// of a row that no trace has covered returns arbitrary coordinates. Status
// reports 1 when a trace touched a row outside the table (that point is
// skipped, the walk goes on) or when a span read asks for a row_index of
// MAX_ROWS or more, in which case all coordinates read as zero.
// ----------------------------------------------------------------------------
module edge_walk_span_table import ewst_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  ewst_req_if.sink    req,
  ewst_rsp_if.source  rsp
);

  localparam int CB = COORD_BITS;
  localparam int PW = COORD_BITS + 3;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = 2 * COORD_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIFF   = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic       kind;

  // Latched request.
  logic [CB-1:0] x1, y1, x2, y2, base;
  logic          side;
  logic [RW-1:0] rd_addr;
  logic          span_miss;

  // Segment setup.
  logic [CB-1:0] adx, ady;
  logic [CB:0]   dxm2, dym2;
  logic          x_le, y_le;

  // Walk state.
  logic [CB-1:0]        x, y, end_major;
  logic signed [PW-1:0] p;
  logic [CB:0]          d_minor, d_major;
  logic                 xmaj, dir_up, stepped, skipped;

  // Output register.
  logic          out_valid;
  logic          out_status;
  logic [EW-1:0] out_left, out_right;

  // Step unit and RAM connections.
  logic signed [PW-1:0] p_next;
  step_flags_t          flags;
  logic [RW-1:0]        row_addr;
  logic                 attempt, wr_en;
  logic [EW-1:0]        wr_data, left_q, right_q;
  logic                 xmaj_now;
  logic                 out_free;
  logic                 out_load;
  logic [CB-1:0]        major_now;

  assign req.ready = (state == S_IDLE);
  assign out_free = ~out_valid | rsp.ready;
  assign out_load = (state == S_FINISH) && out_free;

  ewst_walk #(
    .MAX_ROWS  (MAX_ROWS),
    .COORD_BITS(COORD_BITS)
  ) u_walk (
    .p       (p),
    .d_minor (d_minor),
    .d_major (d_major),
    .y       (y),
    .base    (base),
    .p_next  (p_next),
    .flags   (flags),
    .row_addr(row_addr)
  );

  // Left x-major walks store every point; right x-major walks store only the
  // first point and the first point after each row step; y-major stores all.
  assign attempt = (state == S_WALK) && (~xmaj || ~side || stepped);
  assign wr_en = attempt && ~flags.row_miss;
  assign wr_data = {y, x};

  ewst_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ROWS)
  ) u_left_ram (
    .clk  (clk),
    .we   (wr_en && ~side),
    .waddr(row_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(left_q)
  );

  ewst_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ROWS)
  ) u_right_ram (
    .clk  (clk),
    .we   (wr_en && side),
    .waddr(row_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(right_q)
  );

  // The segment is x-major when the doubled y extent is below the doubled x
  // extent; equal extents and a single point go y-major.
  assign xmaj_now = (dym2 < dxm2);
  assign major_now = xmaj ? x : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new response may load in the same cycle the old one transfers.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind <= req.req_type;
            x1 <= CB'(req.x_start);
            y1 <= CB'(req.y_start);
            x2 <= CB'(req.x_end);
            y2 <= CB'(req.y_end);
            base <= CB'(req.base_row);
            side <= req.right_side;
            rd_addr <= RW'(req.row_index);
            span_miss <= (32'(req.row_index) >= 32'(MAX_ROWS));
            state <= (req.req_type == REQ_SPAN) ? S_READ : S_DIFF;
          end
        end
        S_DIFF: begin
          x_le <= (x1 <= x2);
          y_le <= (y1 <= y2);
          adx <= (x2 >= x1) ? x2 - x1 : x1 - x2;
          ady <= (y2 >= y1) ? y2 - y1 : y1 - y2;
          dxm2 <= {((x2 >= x1) ? x2 - x1 : x1 - x2), 1'b0};
          dym2 <= {((y2 >= y1) ? y2 - y1 : y1 - y2), 1'b0};
          state <= S_INIT;
        end
        S_INIT: begin
          xmaj <= xmaj_now;
          stepped <= 1'b1;
          skipped <= 1'b0;
          if (xmaj_now) begin
            x <= x_le ? x1 : x2;
            y <= x_le ? y1 : y2;
            end_major <= x_le ? x2 : x1;
            dir_up <= x_le ? (y2 > y1) : (y1 > y2);
            d_minor <= dym2;
            d_major <= dxm2;
            p <= $signed(PW'(dym2)) - $signed(PW'(adx));
          end else begin
            x <= y_le ? x1 : x2;
            y <= y_le ? y1 : y2;
            end_major <= y_le ? y2 : y1;
            dir_up <= y_le ? (x2 > x1) : (x1 > x2);
            d_minor <= dxm2;
            d_major <= dym2;
            p <= $signed(PW'(dxm2)) - $signed(PW'(ady));
          end
          state <= S_WALK;
        end
        S_WALK: begin
          if (attempt && flags.row_miss) begin
            skipped <= 1'b1;
          end
          p <= p_next;
          stepped <= flags.minor_step;
          if (xmaj) begin
            x <= x + 1'b1;
            if (flags.minor_step) begin
              y <= dir_up ? y + 1'b1 : y - 1'b1;
            end
          end else begin
            y <= y + 1'b1;
            if (flags.minor_step) begin
              x <= dir_up ? x + 1'b1 : x - 1'b1;
            end
          end
          if (major_now == end_major) begin
            state <= S_FINISH;
          end
        end
        S_READ: begin
          // The RAMs sample rd_addr here; their data is ready next cycle.
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            if (kind == REQ_SPAN) begin
              out_status <= span_miss;
              out_left <= span_miss ? '0 : left_q;
              out_right <= span_miss ? '0 : right_q;
            end else begin
              out_status <= skipped;
              out_left <= '0;
              out_right <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.left_x = FIELD_W'(out_left[CB-1:0]);
  assign rsp.left_y = FIELD_W'(out_left[EW-1:CB]);
  assign rsp.right_x = FIELD_W'(out_right[CB-1:0]);
  assign rsp.right_y = FIELD_W'(out_right[EW-1:CB]);

endmodule
